// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the controller modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_CLK(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_CLK(label, clk, rst_n, expr)

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/ecdc_pkg.sv =====
// ----------------------------------------------------------------------------
// ecdc_pkg
// Shared types, constants and tables of the elevator call and door controller.
// ----------------------------------------------------------------------------
package ecdc_pkg;

    localparam int FLOOR_COUNT_DEF = 5;
    localparam int HALL_COUNT      = 5;
    localparam int CALLS_W         = 5;
    localparam int FLOOR_NUM_W     = 4;
    localparam int QUEUE_DEPTH     = 2;
    localparam int PADDR_W         = 4;
    localparam int PDATA_W         = 32;
    localparam int CFG_W           = 16;

    localparam logic [3:0] KEY_CODE_STAR = 4'd10;
    localparam logic [3:0] KEY_CODE_HASH = 4'd11;

    localparam logic [11:0] PULSE_UP   = 12'd2100;
    localparam logic [11:0] PULSE_DOWN = 12'd900;
    localparam logic [11:0] PULSE_IDLE = 12'd1500;

    localparam logic [CFG_W-1:0] OPEN_BEEP_RST = 16'd300;
    localparam logic [CFG_W-1:0] DOOR_HOLD_RST = 16'd3000;
    localparam logic [CFG_W-1:0] WARN_HALF_RST = 16'd100;
    localparam logic [CFG_W-1:0] SETTLE_RST    = 16'd500;

    typedef enum logic [1:0] {
        CFG_OPEN_BEEP,
        CFG_DOOR_HOLD,
        CFG_WARN_HALF,
        CFG_SETTLE
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KEY_NONE,
        KEY_DIGIT,
        KEY_CLOSE,
        KEY_OPEN
    } t_key_kind;

    typedef struct packed {
        t_key_kind              kind;
        logic [3:0]             digit;
        logic [FLOOR_NUM_W-1:0] call_floor;
        logic [2:0]             seen;
    } t_cmd;

    typedef struct packed {
        logic [CFG_W-1:0] open_beep;
        logic [CFG_W-1:0] door_hold;
        logic [CFG_W-1:0] warn_half;
        logic [CFG_W-1:0] settle;
    } t_cfg;

    function automatic logic [7:0] seg_code(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'hC0;
            4'd1:    s = 8'hF9;
            4'd2:    s = 8'hA4;
            4'd3:    s = 8'hB0;
            4'd4:    s = 8'h99;
            4'd5:    s = 8'h92;
            4'd6:    s = 8'h82;
            4'd7:    s = 8'hF8;
            4'd8:    s = 8'h80;
            4'd9:    s = 8'h90;
            default: s = 8'hFF;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/core/ecdc_front.sv =====
// ----------------------------------------------------------------------------
// ecdc_front
// Classifies one tick: key kind, called floor and lowest sensed floor.
// ----------------------------------------------------------------------------
module ecdc_front #(
    parameter int FLOOR_COUNT = ecdc_pkg::FLOOR_COUNT_DEF
) (
    input  logic            i_key_valid,
    input  logic [3:0]      i_key_code,
    input  logic [4:0]      i_hall_bits,
    output ecdc_pkg::t_cmd  o_cmd
);
    import ecdc_pkg::*;

    localparam logic [FLOOR_NUM_W-1:0] FC = FLOOR_NUM_W'(FLOOR_COUNT);

    logic [FLOOR_NUM_W-1:0] over;

    assign over = i_key_code - FC;

    always_comb begin
        o_cmd            = '0;
        o_cmd.kind       = KEY_NONE;
        o_cmd.digit      = i_key_code;
        if (i_key_valid) begin
            unique case (i_key_code) inside
                [4'd0:4'd9]:   o_cmd.kind = KEY_DIGIT;
                KEY_CODE_STAR: o_cmd.kind = KEY_CLOSE;
                KEY_CODE_HASH: o_cmd.kind = KEY_OPEN;
                default:       o_cmd.kind = KEY_NONE;
            endcase
        end
        if (i_key_code == 4'd0) begin
            o_cmd.call_floor = FC;
        end else if (i_key_code <= FC) begin
            o_cmd.call_floor = i_key_code;
        end else if (over <= FC) begin
            o_cmd.call_floor = over;
        end else begin
            o_cmd.call_floor = '0;
        end
        for (int i = HALL_COUNT - 1; i >= 0; i--) begin
            if (i_hall_bits[i] && (i < FLOOR_COUNT)) begin
                o_cmd.seen = 3'(i + 1);
            end
        end
    end

endmodule

// ===== rtl/core/ecdc_queue.sv =====
// ----------------------------------------------------------------------------
// ecdc_queue
// Short FIFO of classified ticks between the front and the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ecdc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ecdc_pkg::t_cmd  i_data,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output ecdc_pkg::t_cmd  o_data
);
    import ecdc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `ASSERT_CLK(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(QUEUE_DEPTH))
    `ASSERT_IMPL(a_empty_ptrs, i_clk, i_rst_n, r_count == '0, r_wr_ptr == r_rd_ptr)
    `ASSERT_IMPL(a_full_ptrs, i_clk, i_rst_n, o_full, r_wr_ptr == r_rd_ptr)

endmodule

// ===== rtl/core/ecdc_back.sv =====
// ----------------------------------------------------------------------------
// ecdc_back
// Executes one classified tick: calls, goal, floor sensing and door sequence.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ecdc_back #(
    parameter int FLOOR_COUNT = ecdc_pkg::FLOOR_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ecdc_pkg::t_cfg     i_cfg,
    input  logic               i_q_valid,
    input  ecdc_pkg::t_cmd     i_q_data,
    output logic               o_q_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [11:0]        o_motor_pulse,
    output logic               o_buzzer_active,
    output logic [7:0]         o_segment_bits,
    output logic [2:0]         o_floor_now,
    output logic [2:0]         o_goal_now,
    output logic               o_door_open,
    output logic [4:0]         o_calls_pending,
    output logic signed [1:0]  o_heading
);
    import ecdc_pkg::*;

    localparam int PAD_W = (FLOOR_COUNT > CALLS_W) ? FLOOR_COUNT : CALLS_W;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_OPEN_BEEP,
        PH_HOLD,
        PH_WARN_ON,
        PH_WARN_OFF,
        PH_SETTLE
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [CFG_W-1:0]       r_count, n_count;
    logic [1:0]             r_beep, n_beep;
    logic [2:0]             r_floor, n_floor;
    logic [2:0]             r_prior, n_prior;
    logic [FLOOR_NUM_W-1:0] r_goal, n_goal;
    logic [FLOOR_COUNT-1:0] r_req, n_req;
    logic [7:0]             r_seg, n_seg;
    logic signed [1:0]      n_head;
    logic                   r_out_valid;
    logic [CFG_W:0]         cnt_inc;
    logic [PAD_W-1:0]       req_pad;
    logic                   pop;

    assign pop     = i_q_valid && (!r_out_valid || i_ready);
    assign o_q_pop = pop;
    assign o_valid = r_out_valid;
    assign cnt_inc = {1'b0, r_count} + 1'b1;
    assign req_pad = PAD_W'(n_req);

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_beep  = r_beep;
        n_floor = r_floor;
        n_prior = r_prior;
        n_goal  = r_goal;
        n_req   = r_req;
        n_seg   = r_seg;
        n_head  = 2'sd0;

        if (r_phase != PH_IDLE) begin
            n_count = cnt_inc[CFG_W-1:0];
            unique case (r_phase)
                PH_OPEN_BEEP: begin
                    if (cnt_inc >= {1'b0, i_cfg.open_beep}) begin
                        n_phase = PH_HOLD;
                        n_count = '0;
                    end
                end
                PH_HOLD: begin
                    if (cnt_inc >= {1'b0, i_cfg.door_hold}) begin
                        n_phase = PH_WARN_ON;
                        n_count = '0;
                        n_beep  = '0;
                    end
                end
                PH_WARN_ON: begin
                    if (cnt_inc >= {1'b0, i_cfg.warn_half}) begin
                        n_phase = PH_WARN_OFF;
                        n_count = '0;
                    end
                end
                PH_WARN_OFF: begin
                    if (cnt_inc >= {1'b0, i_cfg.warn_half}) begin
                        n_count = '0;
                        if (r_beep >= 2'd2) begin
                            n_beep  = '0;
                            n_phase = (i_cfg.settle == '0) ? PH_IDLE : PH_SETTLE;
                        end else begin
                            n_beep  = r_beep + 1'b1;
                            n_phase = PH_WARN_ON;
                        end
                    end
                end
                PH_SETTLE: begin
                    if (cnt_inc >= {1'b0, i_cfg.settle}) begin
                        n_phase = PH_IDLE;
                        n_count = '0;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_count = '0;
                end
            endcase
        end

        case (i_q_data.kind)
            KEY_DIGIT: begin
                for (int i = 0; i < FLOOR_COUNT; i++) begin
                    if (i_q_data.call_floor == FLOOR_NUM_W'(i + 1)) begin
                        n_req[i] = 1'b1;
                    end
                end
                if (n_phase == PH_IDLE && n_goal == '0) begin
                    n_seg = seg_code(i_q_data.digit);
                end
            end
            KEY_OPEN: begin
                if (n_phase == PH_IDLE && n_goal == '0) begin
                    n_phase = PH_OPEN_BEEP;
                    n_count = '0;
                    n_beep  = '0;
                end
            end
            KEY_CLOSE: begin
                if (n_phase == PH_HOLD) begin
                    n_phase = PH_WARN_ON;
                    n_count = '0;
                    n_beep  = '0;
                end
            end
            default: begin
            end
        endcase

        if (n_phase == PH_IDLE && n_goal == '0) begin
            for (int i = FLOOR_COUNT - 1; i >= 0; i--) begin
                if (n_req[i]) begin
                    n_goal = FLOOR_NUM_W'(i + 1);
                end
            end
            if (n_goal != '0 && n_goal == FLOOR_NUM_W'(n_floor)) begin
                for (int i = 0; i < FLOOR_COUNT; i++) begin
                    if (n_goal == FLOOR_NUM_W'(i + 1)) begin
                        n_req[i] = 1'b0;
                    end
                end
                n_goal  = '0;
                n_phase = PH_OPEN_BEEP;
                n_count = '0;
                n_beep  = '0;
            end
        end

        if (n_goal != '0) begin
            if (i_q_data.seen != '0 && i_q_data.seen != r_prior) begin
                n_floor = i_q_data.seen;
                n_prior = i_q_data.seen;
                n_seg   = seg_code({1'b0, i_q_data.seen});
            end
            if (n_goal == FLOOR_NUM_W'(n_floor)) begin
                for (int i = 0; i < FLOOR_COUNT; i++) begin
                    if (n_goal == FLOOR_NUM_W'(i + 1)) begin
                        n_req[i] = 1'b0;
                    end
                end
                n_goal  = '0;
                n_phase = PH_OPEN_BEEP;
                n_count = '0;
                n_beep  = '0;
            end else begin
                n_head = (n_goal > FLOOR_NUM_W'(n_floor)) ? 2'sd1 : -2'sd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_count     <= '0;
            r_beep      <= '0;
            r_floor     <= 3'd1;
            r_prior     <= 3'd1;
            r_goal      <= '0;
            r_req       <= '0;
            r_seg       <= 8'hFF;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_phase <= n_phase;
                r_count <= n_count;
                r_beep  <= n_beep;
                r_floor <= n_floor;
                r_prior <= n_prior;
                r_goal  <= n_goal;
                r_req   <= n_req;
                r_seg   <= n_seg;
            end
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (pop) begin
            o_motor_pulse   <= (n_head > 2'sd0) ? PULSE_UP :
                               ((n_head < 2'sd0) ? PULSE_DOWN : PULSE_IDLE);
            o_buzzer_active <= (n_phase == PH_OPEN_BEEP) || (n_phase == PH_WARN_ON);
            o_segment_bits  <= n_seg;
            o_floor_now     <= n_floor;
            o_goal_now      <= n_goal[2:0];
            o_door_open     <= (n_phase == PH_OPEN_BEEP) || (n_phase == PH_HOLD) ||
                               (n_phase == PH_WARN_ON) || (n_phase == PH_WARN_OFF);
            o_calls_pending <= req_pad[CALLS_W-1:0];
            o_heading       <= n_head;
        end
    end

    `ASSERT_IMPL(a_goal_door_idle, i_clk, i_rst_n, r_goal != '0, r_phase == PH_IDLE)
    `ASSERT_CLK(a_floor_range, i_clk, i_rst_n, r_floor >= 3'd1 && r_floor <= 3'(HALL_COUNT))
    `ASSERT_CLK(a_beep_bound, i_clk, i_rst_n, r_beep <= 2'd2)

endmodule

// ===== rtl/core/elevator_call_and_door_controller.sv =====
// ----------------------------------------------------------------------------
// elevator_call_and_door_controller
// Call registry, goal selection, floor tracking and door sequencing per tick.
// ----------------------------------------------------------------------------
// One input beat is one millisecond tick carrying an optional released key
// and the hall sensor bits; every tick yields exactly one result beat with
// the motor pulse, buzzer, display pattern, floors, door state, pending calls
// and heading. Both channels use valid and ready.
// A tick is classified in the front stage and pushed into a two-entry queue
// at the edge that accepts it. The back stage pops it, executes it and loads
// the output register once that register is empty or its beat is taken.
// The back stage loads its state registers on each pop, so the controller
// takes one tick per cycle while the receiver takes every result beat.
// When the receiver stalls, the output register holds its beat, the back
// stage stops taking ticks, and input ready drops once the queue holds two.
// Reset restores the timing registers to their defaults, places the car at
// floor 1 with no calls, the door closed and the display blank.
// The timing registers are written through the APB port at byte addresses
// 0, 4, 8 and 12; the user must write them only while no tick is in flight,
// as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module elevator_call_and_door_controller #(
    parameter int FLOOR_COUNT = ecdc_pkg::FLOOR_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_key_valid,
    input  logic [3:0]                    i_key_code,
    input  logic [4:0]                    i_hall_bits,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [11:0]                   o_motor_pulse,
    output logic                          o_buzzer_active,
    output logic [7:0]                    o_segment_bits,
    output logic [2:0]                    o_floor_now,
    output logic [2:0]                    o_goal_now,
    output logic                          o_door_open,
    output logic [4:0]                    o_calls_pending,
    output logic signed [1:0]             o_heading,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ecdc_pkg::PADDR_W-1:0]  paddr,
    input  logic [ecdc_pkg::PDATA_W-1:0]  pwdata,
    output logic [ecdc_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import ecdc_pkg::*;

    t_cfg     r_cfg;
    t_cmd     front_cmd;
    t_cmd     q_data;
    t_cfg_idx cfg_idx;
    logic     q_full;
    logic     q_valid;
    logic     q_pop;
    logic     cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = t_cfg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign o_ready = !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.open_beep <= OPEN_BEEP_RST;
            r_cfg.door_hold <= DOOR_HOLD_RST;
            r_cfg.warn_half <= WARN_HALF_RST;
            r_cfg.settle    <= SETTLE_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                CFG_OPEN_BEEP: r_cfg.open_beep <= pwdata[CFG_W-1:0];
                CFG_DOOR_HOLD: r_cfg.door_hold <= pwdata[CFG_W-1:0];
                CFG_WARN_HALF: r_cfg.warn_half <= pwdata[CFG_W-1:0];
                CFG_SETTLE:    r_cfg.settle    <= pwdata[CFG_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            CFG_OPEN_BEEP: prdata = PDATA_W'(r_cfg.open_beep);
            CFG_DOOR_HOLD: prdata = PDATA_W'(r_cfg.door_hold);
            CFG_WARN_HALF: prdata = PDATA_W'(r_cfg.warn_half);
            CFG_SETTLE:    prdata = PDATA_W'(r_cfg.settle);
        endcase
    end

    ecdc_front #(
        .FLOOR_COUNT (FLOOR_COUNT)
    ) u_front (
        .i_key_valid (i_key_valid),
        .i_key_code  (i_key_code),
        .i_hall_bits (i_hall_bits),
        .o_cmd       (front_cmd)
    );

    ecdc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_data)
    );

    ecdc_back #(
        .FLOOR_COUNT (FLOOR_COUNT)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_q_valid       (q_valid),
        .i_q_data        (q_data),
        .o_q_pop         (q_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_motor_pulse   (o_motor_pulse),
        .o_buzzer_active (o_buzzer_active),
        .o_segment_bits  (o_segment_bits),
        .o_floor_now     (o_floor_now),
        .o_goal_now      (o_goal_now),
        .o_door_open     (o_door_open),
        .o_calls_pending (o_calls_pending),
        .o_heading       (o_heading)
    );

endmodule

// ===== bench/elevator_call_and_door_controller_tb.sv =====
// ----------------------------------------------------------------------------
// elevator_call_and_door_controller_tb
// Self-checking bench for the elevator call and door controller.
// ----------------------------------------------------------------------------
// A short table of directed ticks covers the reset state, ignored keys, the
// open, close and digit keys, and the display rules. After that, random ticks
// drive a simple car that moves with the predicted heading and passes the
// floor magnets, with missed magnets and sensor noise mixed in. The timing
// registers are rewritten between phases, the extremes among them. Every
// result beat is compared field by field with the table or a local prediction
// of the controller. Both sides of the stream idle and stall at random.
// ----------------------------------------------------------------------------
module elevator_call_and_door_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ecdc_pkg::*;

    localparam int FLOORS      = FLOOR_COUNT_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_TAIL  = 4;

    typedef enum logic [2:0] {
        DOOR_IDLE,
        DOOR_OPEN_BEEP,
        DOOR_HOLD,
        DOOR_WARN_ON,
        DOOR_WARN_OFF,
        DOOR_SETTLE
    } t_door;

    typedef enum logic {
        ROW_TICK,
        ROW_TIMING
    } t_row_kind;

    typedef struct packed {
        logic [11:0]       motor;
        logic              buzzer;
        logic [7:0]        segments;
        logic [2:0]        floor_at;
        logic [2:0]        goal_at;
        logic              door;
        logic [4:0]        calls;
        logic signed [1:0] heading;
    } t_tick_out;

    typedef struct packed {
        t_row_kind  kind;
        logic       kv;
        logic [3:0] kc;
        logic [4:0] hall;
        t_cfg_idx   sel;
        logic [15:0] val;
        logic       typed;
        t_tick_out  want;
    } t_dir_row;

    localparam logic [7:0] SEG_PATTERN [10] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
    };

    localparam t_tick_out REST_OUT  = '{PULSE_IDLE, 1'b0, 8'hFF, 3'd1, 3'd0, 1'b0, 5'd0, 2'sd0};
    localparam t_tick_out OPEN_OUT  = '{PULSE_IDLE, 1'b1, 8'hFF, 3'd1, 3'd0, 1'b1, 5'd0, 2'sd0};
    localparam t_tick_out CALL3_OUT = '{PULSE_IDLE, 1'b1, 8'hFF, 3'd1, 3'd0, 1'b1,
                                        5'b00100, 2'sd0};
    localparam t_tick_out NO_OUT    = '0;

    localparam t_dir_row OPENING_ROWS [29] = '{
        '{ROW_TICK,   1'b0, 4'd0,          5'b00000, CFG_OPEN_BEEP, 16'd0, 1'b1, REST_OUT},
        '{ROW_TICK,   1'b1, 4'd12,         5'b11111, CFG_OPEN_BEEP, 16'd0, 1'b1, REST_OUT},
        '{ROW_TICK,   1'b0, 4'd5,          5'b00000, CFG_OPEN_BEEP, 16'd0, 1'b1, REST_OUT},
        '{ROW_TICK,   1'b1, 4'd15,         5'b00000, CFG_OPEN_BEEP, 16'd0, 1'b1, REST_OUT},
        '{ROW_TICK,   1'b1, KEY_CODE_STAR, 5'b00000, CFG_OPEN_BEEP, 16'd0, 1'b1, REST_OUT},
        '{ROW_TICK,   1'b1, KEY_CODE_HASH, 5'b00000, CFG_OPEN_BEEP, 16'd0, 1'b1, OPEN_OUT},
        '{ROW_TICK,   1'b1, KEY_CODE_HASH, 5'b00000, CFG_OPEN_BEEP, 16'd0, 1'b1, OPEN_OUT},
        '{ROW_TICK,   1'b1, 4'd3,          5'b00000, CFG_OPEN_BEEP, 16'd0, 1'b1, CALL3_OUT},
        '{ROW_TIMING, 1'b0, 4'd0,          5'b00000, CFG_OPEN_BEEP, 16'd1, 1'b0, NO_OUT},
        '{ROW_TIMING, 1'b0, 4'd0,          5'b00000, CFG_DOOR_HOLD, 16'd2, 1'b0, NO_OUT},
        '{ROW_TIMING, 1'b0, 4'd0,          5'b00000, CFG_WARN_HALF, 16'd1, 1'b0, NO_OUT},
        '{ROW_TIMING, 1'b0, 4'd0,          5'b00000, CFG_SETTLE,    16'd0, 1'b0, NO_OUT},
        '{ROW_TICK,   1'b0, 4'd0,          5'b00000, CFG_OPEN_BEEP, 16'd0, 1'b0, NO_OUT},
        '{ROW_TICK,   1'b1, KEY_CODE_STAR, 5'b00000, CFG_OPEN_BEEP, 16'd0, 1'b0, NO_OUT},
        '{ROW_TICK,   1'b1, KEY_CODE_STAR, 5'b00000, CFG_OPEN_BEEP, 16'd0, 1'b0, NO_OUT},
        '{ROW_TICK,   1'b0, 4'd0,          5'b00000, CFG_OPEN_BEEP, 16'd0, 1'b0, NO_OUT},
        '{ROW_TICK,   1'b0, 4'd0,          5'b00000, CFG_OPEN_BEEP, 16'd0, 1'b0, NO_OUT},
        '{ROW_TICK,   1'b0, 4'd0,          5'b00000, CFG_OPEN_BEEP, 16'd0, 1'b0, NO_OUT},
        '{ROW_TICK,   1'b0, 4'd0,          5'b00000, CFG_OPEN_BEEP, 16'd0, 1'b0, NO_OUT},
        '{ROW_TICK,   1'b0, 4'd0,          5'b00000, CFG_OPEN_BEEP, 16'd0, 1'b0, NO_OUT},
        '{ROW_TICK,   1'b1, 4'd7,          5'b00000, CFG_OPEN_BEEP, 16'd0, 1'b0, NO_OUT},
        '{ROW_TICK,   1'b0, 4'd0,          5'b00010, CFG_OPEN_BEEP, 16'd0, 1'b0, NO_OUT},
        '{ROW_TICK,   1'b0, 4'd0,          5'b00100, CFG_OPEN_BEEP, 16'd0, 1'b0, NO_OUT},
        '{ROW_TICK,   1'b1, 4'd0,          5'b00000, CFG_OPEN_BEEP, 16'd0, 1'b0, NO_OUT},
        '{ROW_TICK,   1'b1, 4'd9,          5'b00000, CFG_OPEN_BEEP, 16'd0, 1'b0, NO_OUT},
        '{ROW_TICK,   1'b1, 4'd8,          5'b00100, CFG_OPEN_BEEP, 16'd0, 1'b0, NO_OUT},
        '{ROW_TICK,   1'b0, 4'd0,          5'b11000, CFG_OPEN_BEEP, 16'd0, 1'b0, NO_OUT},
        '{ROW_TICK,   1'b0, 4'd0,          5'b10000, CFG_OPEN_BEEP, 16'd0, 1'b0, NO_OUT},
        '{ROW_TICK,   1'b1, 4'd6,          5'b00000, CFG_OPEN_BEEP, 16'd0, 1'b0, NO_OUT}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic                 i_key_valid = 1'b0;
    logic [3:0]           i_key_code = 4'd0;
    logic [4:0]           i_hall_bits = 5'd0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [11:0]          o_motor_pulse;
    logic                 o_buzzer_active;
    logic [7:0]           o_segment_bits;
    logic [2:0]           o_floor_now;
    logic [2:0]           o_goal_now;
    logic                 o_door_open;
    logic [4:0]           o_calls_pending;
    logic signed [1:0]    o_heading;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // Predicted controller state and timing registers.
    int         t_open = int'(OPEN_BEEP_RST);
    int         t_hold = int'(DOOR_HOLD_RST);
    int         t_warn = int'(WARN_HALF_RST);
    int         t_settle = int'(SETTLE_RST);
    int         car_floor = 1;
    int         car_goal = 0;
    int         car_heading = 0;
    int         last_seen_floor = 1;
    logic [4:0] call_bits = '0;
    t_door      door_st = DOOR_IDLE;
    int         door_cnt = 0;
    int         warn_beeps = 0;
    logic [7:0] shown_segments = 8'hFF;

    t_tick_out  due_outputs [$];
    int         car_pos = 10;
    bit         in_steady = 1'b0;
    bit         out_steady = 1'b0;
    int         ready_hold = 0;
    int         errors = 0;
    int         ticks_sent = 0;
    int         beats_checked = 0;
    int         doors_opened = 0;
    int         reg_writes = 0;
    int         cycles = 0;

    elevator_call_and_door_controller u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_key_valid     (i_key_valid),
        .i_key_code      (i_key_code),
        .i_hall_bits     (i_hall_bits),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_motor_pulse   (o_motor_pulse),
        .o_buzzer_active (o_buzzer_active),
        .o_segment_bits  (o_segment_bits),
        .o_floor_now     (o_floor_now),
        .o_goal_now      (o_goal_now),
        .o_door_open     (o_door_open),
        .o_calls_pending (o_calls_pending),
        .o_heading       (o_heading),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: run stopped at the cycle limit", $time);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic open_door();
        door_st = DOOR_OPEN_BEEP;
        door_cnt = 0;
        warn_beeps = 0;
        doors_opened++;
    endtask

    task automatic predict_tick(input logic kv, input logic [3:0] kc, input logic [4:0] hall,
                                output t_tick_out r);
        int fl;
        int seen;
        if (door_st != DOOR_IDLE) begin
            door_cnt++;
            case (door_st)
                DOOR_OPEN_BEEP: begin
                    if (door_cnt >= t_open) begin
                        door_st = DOOR_HOLD;
                        door_cnt = 0;
                    end
                end
                DOOR_HOLD: begin
                    if (door_cnt >= t_hold) begin
                        door_st = DOOR_WARN_ON;
                        door_cnt = 0;
                        warn_beeps = 0;
                    end
                end
                DOOR_WARN_ON: begin
                    if (door_cnt >= t_warn) begin
                        door_st = DOOR_WARN_OFF;
                        door_cnt = 0;
                    end
                end
                DOOR_WARN_OFF: begin
                    if (door_cnt >= t_warn) begin
                        door_cnt = 0;
                        if (warn_beeps >= 2) begin
                            warn_beeps = 0;
                            if (t_settle == 0) door_st = DOOR_IDLE;
                            else door_st = DOOR_SETTLE;
                        end else begin
                            warn_beeps++;
                            door_st = DOOR_WARN_ON;
                        end
                    end
                end
                DOOR_SETTLE: begin
                    if (door_cnt >= t_settle) begin
                        door_st = DOOR_IDLE;
                        door_cnt = 0;
                    end
                end
                default: begin
                    door_st = DOOR_IDLE;
                    door_cnt = 0;
                end
            endcase
        end

        if (kv) begin
            if (kc <= 4'd9) begin
                if (kc == 4'd0) fl = FLOORS;
                else if (int'(kc) <= FLOORS) fl = int'(kc);
                else fl = int'(kc) - FLOORS;
                if (fl >= 1 && fl <= FLOORS) call_bits[fl-1] = 1'b1;
                if (door_st == DOOR_IDLE && car_goal == 0) shown_segments = SEG_PATTERN[kc];
            end else if (kc == KEY_CODE_HASH) begin
                if (door_st == DOOR_IDLE && car_goal == 0) open_door();
            end else if (kc == KEY_CODE_STAR) begin
                if (door_st == DOOR_HOLD) begin
                    door_st = DOOR_WARN_ON;
                    door_cnt = 0;
                    warn_beeps = 0;
                end
            end
        end

        if (door_st == DOOR_IDLE && car_goal == 0) begin
            for (int i = FLOORS - 1; i >= 0; i--) begin
                if (call_bits[i]) car_goal = i + 1;
            end
            if (car_goal != 0 && car_goal == car_floor) begin
                call_bits[car_goal-1] = 1'b0;
                car_goal = 0;
                car_heading = 0;
                open_door();
            end
        end

        if (car_goal != 0) begin
            seen = 0;
            for (int i = HALL_COUNT - 1; i >= 0; i--) begin
                if (i < FLOORS && hall[i]) seen = i + 1;
            end
            if (seen != 0 && seen != last_seen_floor) begin
                car_floor = seen;
                last_seen_floor = seen;
                shown_segments = SEG_PATTERN[seen];
            end
            if (car_floor == car_goal) begin
                call_bits[car_goal-1] = 1'b0;
                car_goal = 0;
                car_heading = 0;
                open_door();
            end else if (car_goal > car_floor) begin
                car_heading = 1;
            end else begin
                car_heading = -1;
            end
        end else begin
            car_heading = 0;
        end

        if (car_heading > 0) r.motor = PULSE_UP;
        else if (car_heading < 0) r.motor = PULSE_DOWN;
        else r.motor = PULSE_IDLE;
        r.buzzer   = (door_st == DOOR_OPEN_BEEP || door_st == DOOR_WARN_ON);
        r.segments = shown_segments;
        r.floor_at = 3'(car_floor);
        r.goal_at  = 3'(car_goal);
        r.door     = (door_st != DOOR_IDLE && door_st != DOOR_SETTLE);
        r.calls    = call_bits;
        r.heading  = 2'(car_heading);
    endtask

    task automatic send_tick(input logic kv, input logic [3:0] kc, input logic [4:0] hall,
                             input logic typed, input t_tick_out typed_out);
        t_tick_out predicted;
        int gap;
        if ($urandom_range(0, 39) == 0) in_steady = !in_steady;
        gap = in_steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_key_valid <= kv;
        i_key_code  <= kc;
        i_hall_bits <= hall;
        do @(posedge i_clk); while (!o_ready);
        predict_tick(kv, kc, hall, predicted);
        due_outputs.push_back(typed ? typed_out : predicted);
        ticks_sent++;
    endtask

    task automatic drain_outputs();
        i_valid <= 1'b0;
        while (due_outputs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    task automatic write_timing(input t_cfg_idx sel, input logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= {16'h0000, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (sel)
            CFG_OPEN_BEEP: t_open = int'(val);
            CFG_DOOR_HOLD: t_hold = int'(val);
            CFG_WARN_HALF: t_warn = int'(val);
            default:       t_settle = int'(val);
        endcase
        reg_writes++;
    endtask

    task automatic apply_timing(input logic [15:0] open_t, input logic [15:0] hold_t,
                                input logic [15:0] warn_t, input logic [15:0] settle_t);
        drain_outputs();
        write_timing(CFG_OPEN_BEEP, open_t);
        write_timing(CFG_DOOR_HOLD, hold_t);
        write_timing(CFG_WARN_HALF, warn_t);
        write_timing(CFG_SETTLE, settle_t);
    endtask

    task automatic run_random_ticks(input int count);
        logic       kv;
        logic [3:0] kc;
        logic [4:0] hall;
        int         pick;
        for (int n = 0; n < count; n++) begin
            if (car_heading != 0 && $urandom_range(0, 1) == 1) car_pos += car_heading;
            if (car_pos < 10) car_pos = 10;
            if (car_pos > 50) car_pos = 50;
            hall = '0;
            if (car_pos % 10 == 0 && $urandom_range(0, 19) != 0) hall[car_pos/10 - 1] = 1'b1;
            if ($urandom_range(0, 9) == 0) hall = 5'($urandom);
            kv = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (!kv) kc = 4'($urandom);
            else if (pick < 60) kc = 4'($urandom_range(0, 9));
            else if (pick < 75) kc = KEY_CODE_STAR;
            else if (pick < 90) kc = KEY_CODE_HASH;
            else kc = 4'($urandom_range(12, 15));
            send_tick(kv, kc, hall, 1'b0, NO_OUT);
        end
    endtask

    task automatic check_field(input string name, input logic signed [15:0] want,
                               input logic signed [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_tick_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (due_outputs.size() == 0) begin
                $display("%0t: result beat arrived with no tick waiting", $time);
                errors++;
            end else begin
                want = due_outputs.pop_front();
                check_field("motor_pulse", 16'(want.motor), 16'(o_motor_pulse));
                check_field("buzzer_active", 16'(want.buzzer), 16'(o_buzzer_active));
                check_field("segment_bits", 16'(want.segments), 16'(o_segment_bits));
                check_field("floor_now", 16'(want.floor_at), 16'(o_floor_now));
                check_field("goal_now", 16'(want.goal_at), 16'(o_goal_now));
                check_field("door_open", 16'(want.door), 16'(o_door_open));
                check_field("calls_pending", 16'(want.calls), 16'(o_calls_pending));
                check_field("heading", 16'(want.heading), 16'(o_heading));
                beats_checked++;
            end
            if ($urandom_range(0, 39) == 0) out_steady = !out_steady;
            ready_hold = out_steady ? 0 : $urandom_range(0, 3);
        end
        if (ready_hold > 0) begin
            i_ready <= 1'b0;
            ready_hold--;
        end else begin
            i_ready <= 1'b1;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < $size(OPENING_ROWS); r++) begin
            if (OPENING_ROWS[r].kind == ROW_TIMING) begin
                drain_outputs();
                write_timing(OPENING_ROWS[r].sel, OPENING_ROWS[r].val);
            end else begin
                send_tick(OPENING_ROWS[r].kv, OPENING_ROWS[r].kc, OPENING_ROWS[r].hall,
                          OPENING_ROWS[r].typed, OPENING_ROWS[r].want);
            end
        end

        apply_timing(16'd2, 16'd6, 16'd1, 16'd0);
        run_random_ticks(150);
        apply_timing(16'd1, 16'd1, 16'd2, 16'd1);
        run_random_ticks(150);
        apply_timing(16'd65535, 16'd65535, 16'd65535, 16'd65535);
        run_random_ticks(60);
        apply_timing(16'd3, 16'd4, 16'd1, 16'd3);
        run_random_ticks(190);
        drain_outputs();

        $display("Checked %0d result beats from %0d ticks across %0d register writes.",
                 beats_checked, ticks_sent, reg_writes);
        $display("The door opened %0d times while the car chased calls with noisy sensors.",
                 doors_opened);
        if (errors == 0 && due_outputs.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/ecdc_pkg.sv
rtl/core/ecdc_front.sv
rtl/core/ecdc_queue.sv
rtl/core/ecdc_back.sv
rtl/core/elevator_call_and_door_controller.sv
bench/elevator_call_and_door_controller_tb.sv
